// ===== rtl/core/sgt_pkg.sv =====
// Shared package for the square grid transposition block.
// Holds the request and response payload types, the sequencer and phase
// encodings, and the default string capacity. No dependencies.
`timescale 1ns / 1ps

package sgt_pkg;

    localparam int unsigned MAX_LEN = 256;

    localparam logic [7:0] SPACE_CHAR = 8'd32;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_PUSH
    } state_t;

    typedef enum logic [1:0] {
        PH_EMPTY,
        PH_LOADING,
        PH_READING
    } phase_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] in_char;
        logic       in_last;
    } req_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
        logic       out_valid;
    } rsp_t;

endpackage

// ===== rtl/core/sgt_isqrt.sv =====
// Iterative grid sizing unit: integer square root by running odd-number sums.
// Produces the row and column counts of the grid for a string length.
// Depends on: nothing outside this file.
`timescale 1ns / 1ps

module sgt_isqrt #(
    parameter int unsigned CNT_W  = 9,
    parameter int unsigned ROOT_W = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CNT_W-1:0]  len,
    output logic              done,
    output logic [ROOT_W-1:0] rows,
    output logic [ROOT_W-1:0] cols
);

    localparam int unsigned SQ_W = CNT_W + 2;

    logic              run_reg;
    logic              done_reg;
    logic [SQ_W-1:0]   len_reg;
    logic [ROOT_W-1:0] r_reg;
    logic [SQ_W-1:0]   sq_reg;      // (r + 1)^2
    logic [SQ_W-1:0]   sq_lo_reg;   // r^2
    logic [ROOT_W-1:0] rows_reg;
    logic [ROOT_W-1:0] cols_reg;

    logic              step;
    logic              exact;
    logic              near;
    logic [SQ_W-1:0]   r_ext;
    logic [SQ_W-1:0]   sq_next;
    logic [ROOT_W-1:0] r_inc;

    always_comb
    begin
        r_ext   = SQ_W'(r_reg);
        r_inc   = r_reg + ROOT_W'(1);
        step    = (sq_reg <= len_reg);
        exact   = (sq_lo_reg == len_reg);
        near    = ((sq_lo_reg + r_ext) <= len_reg);
        sq_next = sq_reg + (r_ext << 1) + SQ_W'(3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (run_reg && !step)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            len_reg   <= SQ_W'(len);
            r_reg     <= '0;
            sq_reg    <= SQ_W'(1);
            sq_lo_reg <= '0;
        end
        else if (run_reg)
        begin
            if (step)
            begin
                r_reg     <= r_inc;
                sq_lo_reg <= sq_reg;
                sq_reg    <= sq_next;
            end
            else
            begin
                rows_reg <= (exact || near) ? r_inc : r_reg;
                cols_reg <= exact ? r_reg : r_inc;
            end
        end
    end

    assign done = done_reg;
    assign rows = rows_reg;
    assign cols = cols_reg;

endmodule

// ===== rtl/core/square_grid_transposition.sv =====
// Top level of the square grid transposition block: text store, read-out
// sequencer and response register. Uses sgt_pkg and sgt_isqrt.
// A fetch goes through a lookup and then the response register, and no new
// request is taken until its response is in that register. The load that
// closes a string is followed by grid sizing in the square-root unit,
// during which no request is taken. A full string of L characters yields
// L + ceil(sqrt(L)) response characters, the last one a space with out_last.
`timescale 1ns / 1ps

module square_grid_transposition #(
    parameter int unsigned MAX_LEN = sgt_pkg::MAX_LEN
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  sgt_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output sgt_pkg::rsp_t rsp_data
);

    localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);
    localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned ROOT_W = (CNT_W + 1) / 2 + 1;
    localparam int unsigned IDX_W  = CNT_W + 1;

    sgt_pkg::state_t   state_reg, state_next;
    sgt_pkg::phase_t   phase_reg, phase_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ROOT_W-1:0] rows_reg, rows_next;
    logic [ROOT_W-1:0] cols_reg, cols_next;
    logic [ROOT_W-1:0] col_reg, col_next;
    logic [ROOT_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    logic              pend_mem_reg, pend_mem_next;
    logic [7:0]        pend_char_reg, pend_char_next;
    logic              pend_last_reg, pend_last_next;
    logic              pend_ok_reg, pend_ok_next;

    logic              rsp_valid_reg, rsp_valid_next;
    sgt_pkg::rsp_t     rsp_data_reg, rsp_data_next;

    logic [7:0]        text_store [MAX_LEN];
    logic [7:0]        rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_re;

    logic              accept;
    logic [CNT_W-1:0]  count_base;
    logic              cell_ok;
    logic [ROOT_W-1:0] col_inc;
    logic              root_start;
    logic              root_done;
    logic [ROOT_W-1:0] root_rows;
    logic [ROOT_W-1:0] root_cols;

    sgt_isqrt #(
        .CNT_W  (CNT_W),
        .ROOT_W (ROOT_W)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .len   (count_next),
        .done  (root_done),
        .rows  (root_rows),
        .cols  (root_cols)
    );

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        idx_next       = idx_reg;
        pend_mem_next  = pend_mem_reg;
        pend_char_next = pend_char_reg;
        pend_last_next = pend_last_reg;
        pend_ok_next   = pend_ok_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        root_start     = 1'b0;
        req_ready      = 1'b0;

        count_base = (phase_reg == sgt_pkg::PH_LOADING) ? count_reg : '0;
        mem_waddr  = count_base[ADDR_W-1:0];
        cell_ok    = (row_reg < rows_reg) && (idx_reg < IDX_W'(count_reg));
        col_inc    = col_reg + ROOT_W'(1);

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            sgt_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (accept)
                begin
                    if (req_data.cmd == sgt_pkg::CMD_LOAD)
                    begin
                        phase_next = sgt_pkg::PH_LOADING;
                        count_next = count_base;
                        if (count_base < CNT_W'(MAX_LEN))
                        begin
                            mem_we     = 1'b1;
                            count_next = count_base + CNT_W'(1);
                        end
                        if (req_data.in_last)
                        begin
                            root_start = 1'b1;
                            state_next = sgt_pkg::ST_ROOT;
                        end
                    end
                    else
                    begin
                        state_next     = sgt_pkg::ST_PUSH;
                        pend_mem_next  = 1'b0;
                        pend_char_next = '0;
                        pend_last_next = 1'b0;
                        pend_ok_next   = (phase_reg == sgt_pkg::PH_READING);
                        if (phase_reg == sgt_pkg::PH_READING)
                        begin
                            if (cell_ok)
                            begin
                                mem_re        = 1'b1;
                                pend_mem_next = 1'b1;
                                row_next      = row_reg + ROOT_W'(1);
                                idx_next      = idx_reg + IDX_W'(cols_reg);
                            end
                            else
                            begin
                                pend_char_next = sgt_pkg::SPACE_CHAR;
                                row_next       = '0;
                                if (col_inc >= cols_reg)
                                begin
                                    pend_last_next = 1'b1;
                                    col_next       = '0;
                                    idx_next       = '0;
                                    count_next     = '0;
                                    phase_next     = sgt_pkg::PH_EMPTY;
                                end
                                else
                                begin
                                    col_next = col_inc;
                                    idx_next = IDX_W'(col_inc);
                                end
                            end
                        end
                    end
                end
            end

            sgt_pkg::ST_ROOT:
            begin
                if (root_done)
                begin
                    rows_next  = root_rows;
                    cols_next  = root_cols;
                    col_next   = '0;
                    row_next   = '0;
                    idx_next   = '0;
                    phase_next = sgt_pkg::PH_READING;
                    state_next = sgt_pkg::ST_IDLE;
                end
            end

            sgt_pkg::ST_PUSH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_data_next.out_char  = pend_mem_reg ? rd_data_reg : pend_char_reg;
                    rsp_data_next.out_last  = pend_last_reg;
                    rsp_data_next.out_valid = pend_ok_reg;
                    state_next              = sgt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sgt_pkg::ST_IDLE;
            end
        endcase
    end

    assign accept = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sgt_pkg::ST_IDLE;
            phase_reg     <= sgt_pkg::PH_EMPTY;
            count_reg     <= '0;
            rows_reg      <= '0;
            cols_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_mem_reg  <= pend_mem_next;
        pend_char_reg <= pend_char_next;
        pend_last_reg <= pend_last_next;
        pend_ok_reg   <= pend_ok_next;
        rsp_data_reg  <= rsp_data_next;
    end

    // text store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            text_store[mem_waddr] <= req_data.in_char;
        if (mem_re)
            rd_data_reg <= text_store[idx_reg[ADDR_W-1:0]];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule
